// ===== src/uv_sphere_triangle_generator_top_macros.svh =====
// Assertion macros for the UV sphere triangle generator checker.
// The enclosing scope must provide clk and rst_n.
`ifndef UV_SPHERE_TRIANGLE_GENERATOR_TOP_MACROS_SVH
`define UV_SPHERE_TRIANGLE_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define UVS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uvs assertion failed");

// Next-cycle implication.
`define UVS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uvs assertion failed");

`endif

// ===== src/uvs_pkg.sv =====
// Package for the UV sphere triangle generator: pipeline types, codes and tables.
// No dependencies.
package uvs_pkg;

  localparam int NST = 25;
  localparam int ST_X = 1;
  localparam int ST_X2 = 2;
  localparam int ST_HORN = 3;
  localparam int ST_SIN = 21;
  localparam int ST_SIGN = 22;
  localparam int ST_PROD = 23;

  localparam logic [1:0] KIND_VTX = 2'd0;
  localparam logic [1:0] KIND_POS = 2'd1;
  localparam logic [1:0] KIND_NEG = 2'd2;
  localparam logic [1:0] KIND_ERR = 2'd3;

  localparam logic [2:0] REG_STRIP = 3'd0;
  localparam logic [2:0] REG_BAND = 3'd1;
  localparam logic [2:0] REG_AZI = 3'd2;
  localparam logic [2:0] REG_POL = 3'd3;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;

  // Cosine divisors per Horner slot; the sine uses slots one to five.
  localparam logic [7:0] CDIV [6] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [7:0] SDIV [6] = '{8'd2, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [32:0] CRCP [6] = '{
    33'(64'd4294967296 / 64'd132), 33'(64'd4294967296 / 64'd90),
    33'(64'd4294967296 / 64'd56), 33'(64'd4294967296 / 64'd30),
    33'(64'd4294967296 / 64'd12), 33'(64'd4294967296 / 64'd2)};
  localparam logic [32:0] SRCP [6] = '{
    33'(64'd4294967296 / 64'd2), 33'(64'd4294967296 / 64'd110),
    33'(64'd4294967296 / 64'd72), 33'(64'd4294967296 / 64'd42),
    33'(64'd4294967296 / 64'd20), 33'(64'd4294967296 / 64'd6)};

  typedef struct packed {
    logic [1:0]  quad;
    logic        fold;
    logic [29:0] x;
    logic [29:0] x2;
    logic [30:0] ts;
    logic [30:0] tc;
    logic [30:0] vs;
    logic [30:0] vc;
    logic [30:0] qs;
    logic [30:0] qc;
    logic        sn;
    logic        cn;
  } ang_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic [1:0]  kind;
    ang_t        pol;
    ang_t        azi;
    logic [61:0] py;
    logic [61:0] pz;
    logic        ny;
    logic        nz;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] cz;
  } pip_t;

  function automatic ang_t ang_turn(logic [8:0] idx, logic [15:0] step);
    logic [24:0] prod;
    logic [13:0] r;
    ang_t o;
    o = '0;
    prod = 25'(idx) * 25'(step);
    o.quad = prod[15:14];
    r = prod[13:0];
    o.fold = r > 14'd8192;
    o.x = 30'(o.fold ? 14'(15'd16384 - 15'(r)) : r);
    return o;
  endfunction

  function automatic ang_t ang_x(ang_t a);
    logic [46:0] p;
    ang_t o;
    o = a;
    p = 47'(a.x[13:0]) * 47'(TWO_PI_Q30);
    o.x = 30'(p >> 16);
    return o;
  endfunction

  function automatic ang_t ang_x2(ang_t a);
    logic [59:0] p;
    ang_t o;
    o = a;
    p = 60'(a.x) * 60'(a.x);
    o.x2 = 30'(p >> 30);
    o.ts = Q30_ONE;
    o.tc = Q30_ONE;
    return o;
  endfunction

  function automatic ang_t ang_mul(ang_t a);
    logic [61:0] pc;
    logic [61:0] ps;
    ang_t o;
    o = a;
    pc = 62'(a.x2) * 62'(a.tc);
    ps = 62'(a.x2) * 62'(a.ts);
    o.vc = 31'(pc >> 30);
    o.vs = 31'(ps >> 30);
    return o;
  endfunction

  function automatic ang_t ang_rcp(ang_t a, int k);
    logic [63:0] pc;
    logic [63:0] ps;
    ang_t o;
    o = a;
    pc = 64'(a.vc) * 64'(CRCP[k]);
    ps = 64'(a.vs) * 64'(SRCP[k]);
    o.qc = 31'(pc >> 32);
    o.qs = 31'(ps >> 32);
    return o;
  endfunction

  function automatic logic [30:0] quo_fix(logic [30:0] v, logic [30:0] q, logic [7:0] d);
    logic [38:0] qd;
    logic [30:0] rem;
    qd = 39'(q) * 39'(d);
    rem = v - 31'(qd);
    return (rem >= 31'(d)) ? q + 31'd1 : q;
  endfunction

  function automatic ang_t ang_fix(ang_t a, int k);
    ang_t o;
    o = a;
    o.tc = Q30_ONE - quo_fix(a.vc, a.qc, CDIV[k]);
    if (k != 0) begin
      o.ts = Q30_ONE - quo_fix(a.vs, a.qs, SDIV[k]);
    end
    return o;
  endfunction

  function automatic ang_t ang_sin(ang_t a);
    logic [61:0] p;
    ang_t o;
    o = a;
    p = 62'(a.x) * 62'(a.ts);
    o.ts = 31'(p >> 30);
    return o;
  endfunction

  function automatic ang_t ang_sign(ang_t a);
    logic [30:0] s;
    logic [30:0] c;
    ang_t o;
    o = a;
    s = a.fold ? a.tc : a.ts;
    c = a.fold ? a.ts : a.tc;
    case (a.quad)
      2'd0: begin o.ts = s; o.sn = 1'b0; o.tc = c; o.cn = 1'b0; end
      2'd1: begin o.ts = c; o.sn = 1'b0; o.tc = s; o.cn = 1'b1; end
      2'd2: begin o.ts = s; o.sn = 1'b1; o.tc = c; o.cn = 1'b1; end
      default: begin o.ts = c; o.sn = 1'b1; o.tc = s; o.cn = 1'b0; end
    endcase
    return o;
  endfunction

  function automatic logic [15:0] sat16(logic [16:0] m, logic neg);
    logic [16:0] r;
    if (!neg) begin
      r = (m > 17'd32767) ? 17'd32767 : m;
    end else begin
      r = 17'd0 - ((m > 17'd32768) ? 17'd32768 : m);
    end
    return r[15:0];
  endfunction

endpackage

// ===== src/uv_sphere_triangle_generator_top.sv =====
// UV sphere triangle generator, top level with the full vertex pipeline.
// Depends on uvs_pkg.
//
// Usage: each transaction on the in_ channel names a strip (in_tdata[7:0]) and a
// band (in_tdata[15:8]). The block returns the triangle vertices of that cell on
// the out_ channel, one vertex per transaction: x, y, z in Q1.15 packed in
// out_tdata, out_tlast on the final vertex of the cell, out_tuser set when the
// cell index is out of range (a single all-zero vertex is then returned).
// The cfg_ channel writes strip count, band count, azimuth step and polar step
// by index 0 to 3; it is always ready and must be written only while the block idles,
// which the block itself does not enforce. Throughput is one vertex per cycle while
// the receiver does not stall, set by the single vertex issue slot: a middle band
// cell yields 6 vertices, a cap band 3 and an out-of-range cell 1. Each transaction
// passes the issue register and 25 pipeline stages of Horner sine and cosine evaluation.
// Reset restores the register defaults and empties the pipeline.
// When the receiver stalls, the whole pipeline holds and no vertex is lost.
module uv_sphere_triangle_generator_top
  import uvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] strip_index, [15:8] band_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] coord_x, [31:16] coord_y, [47:32] coord_z
  output logic        out_tlast,  // last_vertex
  output logic        out_tuser,  // index_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [1:0] CLS_ERR = 2'd0;
  localparam logic [1:0] CLS_TOP = 2'd1;
  localparam logic [1:0] CLS_BOT = 2'd2;
  localparam logic [1:0] CLS_MID = 2'd3;

  logic [8:0]  strip_count_r;
  logic [8:0]  band_count_r;
  logic [15:0] azimuth_step_r;
  logic [15:0] polar_step_r;

  logic        busy_r;
  logic [7:0]  strip_r;
  logic [7:0]  band_r;
  logic [1:0]  cls_r;
  logic [2:0]  cnt_r;

  pip_t        pipe_r [NST];
  pip_t        pipe_nxt [NST];

  logic        en;
  logic        issue_last;
  logic [8:0]  vp;
  logic [8:0]  va;
  logic [1:0]  vkind;
  logic [1:0]  cls_nxt;
  logic [7:0]  in_strip;
  logic [7:0]  in_band;

  assign cfg_ready = 1'b1;
  assign in_strip = in_tdata[7:0];
  assign in_band = in_tdata[15:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_count_r <= 9'd16;
      band_count_r <= 9'd16;
      azimuth_step_r <= 16'd4096;
      polar_step_r <= 16'd2048;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STRIP: strip_count_r <= cfg_data[8:0];
        REG_BAND: band_count_r <= cfg_data[8:0];
        REG_AZI: azimuth_step_r <= cfg_data;
        REG_POL: polar_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en = !pipe_r[NST-1].valid || out_tready;

  always_comb begin
    if ({1'b0, in_strip} >= strip_count_r || {1'b0, in_band} >= band_count_r) begin
      cls_nxt = CLS_ERR;
    end else if (in_band == 8'd0) begin
      cls_nxt = CLS_TOP;
    end else if ({1'b0, in_band} == band_count_r - 9'd1) begin
      cls_nxt = CLS_BOT;
    end else begin
      cls_nxt = CLS_MID;
    end
  end

  always_comb begin
    vp = {1'b0, band_r};
    va = {1'b0, strip_r};
    vkind = KIND_VTX;
    issue_last = 1'b0;
    case (cls_r)
      CLS_ERR: begin
        vkind = KIND_ERR;
        issue_last = 1'b1;
      end
      CLS_TOP: begin
        vp = 9'd1;
        vkind = (cnt_r == 3'd0) ? KIND_POS : KIND_VTX;
        va = {1'b0, strip_r} + ((cnt_r == 3'd1) ? 9'd1 : 9'd0);
        issue_last = cnt_r == 3'd2;
      end
      CLS_BOT: begin
        vkind = (cnt_r == 3'd0) ? KIND_NEG : KIND_VTX;
        va = {1'b0, strip_r} + ((cnt_r == 3'd2) ? 9'd1 : 9'd0);
        issue_last = cnt_r == 3'd2;
      end
      default: begin
        vp = {1'b0, band_r} + ((cnt_r == 3'd2 || cnt_r == 3'd3 || cnt_r == 3'd5) ?
                               9'd1 : 9'd0);
        va = {1'b0, strip_r} + ((cnt_r == 3'd1 || cnt_r == 3'd4 || cnt_r == 3'd5) ?
                                9'd1 : 9'd0);
        issue_last = cnt_r == 3'd5;
      end
    endcase
  end

  assign in_tready = !busy_r || (en && issue_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      busy_r <= 1'b1;
    end else if (en && issue_last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      strip_r <= in_strip;
      band_r <= in_band;
      cls_r <= cls_nxt;
      cnt_r <= 3'd0;
    end else if (en && busy_r) begin
      cnt_r <= cnt_r + 3'd1;
    end
  end

  always_comb begin
    pipe_nxt[0] = '0;
    pipe_nxt[0].valid = busy_r;
    pipe_nxt[0].last = issue_last;
    pipe_nxt[0].kind = vkind;
    pipe_nxt[0].pol = ang_turn(vp, polar_step_r);
    pipe_nxt[0].azi = ang_turn(va, azimuth_step_r);
  end

  for (genvar gi = 1; gi < NST; gi++) begin : g_stage
    localparam int K = (gi >= ST_HORN) ? (gi - ST_HORN) / 3 : 0;
    localparam int J = (gi >= ST_HORN) ? (gi - ST_HORN) % 3 : 0;
    always_comb begin
      pipe_nxt[gi] = pipe_r[gi-1];
      if (gi == ST_X) begin
        pipe_nxt[gi].pol = ang_x(pipe_r[gi-1].pol);
        pipe_nxt[gi].azi = ang_x(pipe_r[gi-1].azi);
      end else if (gi == ST_X2) begin
        pipe_nxt[gi].pol = ang_x2(pipe_r[gi-1].pol);
        pipe_nxt[gi].azi = ang_x2(pipe_r[gi-1].azi);
      end else if (gi < ST_SIN) begin
        if (J == 0) begin
          pipe_nxt[gi].pol = ang_mul(pipe_r[gi-1].pol);
          pipe_nxt[gi].azi = ang_mul(pipe_r[gi-1].azi);
        end else if (J == 1) begin
          pipe_nxt[gi].pol = ang_rcp(pipe_r[gi-1].pol, K);
          pipe_nxt[gi].azi = ang_rcp(pipe_r[gi-1].azi, K);
        end else begin
          pipe_nxt[gi].pol = ang_fix(pipe_r[gi-1].pol, K);
          pipe_nxt[gi].azi = ang_fix(pipe_r[gi-1].azi, K);
        end
      end else if (gi == ST_SIN) begin
        pipe_nxt[gi].pol = ang_sin(pipe_r[gi-1].pol);
        pipe_nxt[gi].azi = ang_sin(pipe_r[gi-1].azi);
      end else if (gi == ST_SIGN) begin
        pipe_nxt[gi].pol = ang_sign(pipe_r[gi-1].pol);
        pipe_nxt[gi].azi = ang_sign(pipe_r[gi-1].azi);
      end else if (gi == ST_PROD) begin
        pipe_nxt[gi].py = 62'(pipe_r[gi-1].azi.ts) * 62'(pipe_r[gi-1].pol.ts);
        pipe_nxt[gi].pz = 62'(pipe_r[gi-1].azi.tc) * 62'(pipe_r[gi-1].pol.ts);
        pipe_nxt[gi].ny = pipe_r[gi-1].azi.sn ^ pipe_r[gi-1].pol.sn;
        pipe_nxt[gi].nz = pipe_r[gi-1].azi.cn ^ pipe_r[gi-1].pol.sn;
      end else begin
        pipe_nxt[gi].cx = sat16(17'((32'(pipe_r[gi-1].pol.tc) + 32'd16384) >> 15),
                                pipe_r[gi-1].pol.cn);
        pipe_nxt[gi].cy = sat16(17'((pipe_r[gi-1].py + 62'(64'd1 << 44)) >> 45),
                                pipe_r[gi-1].ny);
        pipe_nxt[gi].cz = sat16(17'((pipe_r[gi-1].pz + 62'(64'd1 << 44)) >> 45),
                                pipe_r[gi-1].nz);
        case (pipe_r[gi-1].kind)
          KIND_POS: begin
            pipe_nxt[gi].cx = 16'h7fff;
            pipe_nxt[gi].cy = 16'h0000;
            pipe_nxt[gi].cz = 16'h0000;
          end
          KIND_NEG: begin
            pipe_nxt[gi].cx = 16'h8000;
            pipe_nxt[gi].cy = 16'h0000;
            pipe_nxt[gi].cz = 16'h0000;
          end
          KIND_ERR: begin
            pipe_nxt[gi].cx = 16'h0000;
            pipe_nxt[gi].cy = 16'h0000;
            pipe_nxt[gi].cz = 16'h0000;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) begin
        pipe_r[i].valid <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < NST; i++) begin
        pipe_r[i] <= pipe_nxt[i];
      end
    end
  end

  assign out_tvalid = pipe_r[NST-1].valid;
  assign out_tdata = {pipe_r[NST-1].cz, pipe_r[NST-1].cy, pipe_r[NST-1].cx};
  assign out_tlast = pipe_r[NST-1].last;
  assign out_tuser = pipe_r[NST-1].kind == KIND_ERR;

endmodule

// ===== src/uvs_chk.sv =====
// Port-level checker for the UV sphere triangle generator, bound to the top level.
// Depends on uv_sphere_triangle_generator_top_macros.svh.
`include "uv_sphere_triangle_generator_top_macros.svh"

module uvs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  `UVS_ASSERT_IMP(a_err_last, out_tvalid && out_tuser, out_tlast)
  `UVS_ASSERT_IMP(a_err_zero, out_tvalid && out_tuser, out_tdata == 48'd0)
  `UVS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready,
                  out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind uv_sphere_triangle_generator_top uvs_chk u_chk (
  .clk(clk),
  .rst_n(rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata),
  .out_tlast(out_tlast),
  .out_tuser(out_tuser)
);
